>>> sv/rsd_pkg.sv
// Package for the sprite row RLE decoder: item types, command struct,
// register indexes and defaults. No dependencies.
`default_nettype none
package rsd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CTRL_TRANSPARENT_BIT = 8'h80;
	localparam logic [7:0] CTRL_REPEAT_BIT      = 8'h40;
	localparam logic [7:0] TRANSPARENT_VALUE    = 8'hFF;

	localparam logic [7:0] FRAME_WIDTH_RESET  = 8'd64;
	localparam logic [7:0] FRAME_HEIGHT_RESET = 8'd64;

	localparam int unsigned PADDR_W  = 3;
	localparam logic        REG_FRAME_WIDTH  = 1'b0;
	localparam logic        REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		PHASE_CTRL    = 2'd0,
		PHASE_REPEAT  = 2'd1,
		PHASE_LITERAL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] code_byte;
	} code_item_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [6:0] run_length;
		logic       row_end;
		logic       frame_end;
		logic       overrun;
	} run_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic [6:0] len;
		logic       group_done;
	} run_cmd_t;

endpackage
`default_nettype wire

>>> sv/rsd_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for the code byte and run channels; no dependencies.
`default_nettype none
interface rsd_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/rsd_front.sv
// Front end: takes code bytes, tracks control, repeat and literal phases,
// and issues run commands. Depends on rsd_pkg.
`default_nettype none
module rsd_front import rsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] code_byte,
	input  wire logic       cmd_full,
	output logic            cmd_push,
	output run_cmd_t        cmd
);

	phase_t     phase_q, phase_d;
	logic [5:0] left_q, left_d;
	logic [5:0] left_dec;
	logic       cmd_valid;
	logic       take;

	assign in_ready = !cmd_full;
	assign take     = in_valid && in_ready;
	assign cmd_push = take && cmd_valid;
	assign left_dec = left_q - 6'd1;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		unique case (phase_q)
			PHASE_REPEAT: begin
				phase_d = PHASE_CTRL;
				left_d  = '0;
			end
			PHASE_LITERAL: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PHASE_CTRL;
				end
			end
			PHASE_CTRL: begin
				if ((code_byte & CTRL_TRANSPARENT_BIT) == '0) begin
					if ((code_byte & CTRL_REPEAT_BIT) != '0) begin
						phase_d = PHASE_REPEAT;
						left_d  = code_byte[5:0];
					end else if (code_byte[5:0] != '0) begin
						phase_d = PHASE_LITERAL;
						left_d  = code_byte[5:0];
					end
				end
			end
			default: begin
				phase_d = PHASE_CTRL;
			end
		endcase
	end

	always_comb begin
		cmd_valid      = 1'b0;
		cmd.value      = code_byte;
		cmd.len        = 7'd1;
		cmd.group_done = 1'b1;
		unique case (phase_q)
			PHASE_REPEAT: begin
				cmd_valid = left_q != '0;
				cmd.len   = {1'b0, left_q};
			end
			PHASE_LITERAL: begin
				cmd_valid      = 1'b1;
				cmd.group_done = left_dec == '0;
			end
			PHASE_CTRL: begin
				cmd.value = TRANSPARENT_VALUE;
				cmd.len   = code_byte[6:0];
				cmd_valid = ((code_byte & CTRL_TRANSPARENT_BIT) != '0) &&
					(code_byte[6:0] != '0);
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_CTRL;
			left_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

	a_literal_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PHASE_LITERAL |-> left_q != '0)
		else $error("literal phase with no bytes left");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");
	a_ctrl_after_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PHASE_REPEAT |=> phase_q == PHASE_CTRL)
		else $error("repeat value did not return to control phase");

endmodule
`default_nettype wire

>>> sv/rsd_queue.sv
// Short command queue between the front and back ends.
// Register-based circular buffer; depends on rsd_pkg.
`default_nettype none
module rsd_queue import rsd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire run_cmd_t push_data,
	output logic          full,
	input  wire logic     pop,
	output logic          not_empty,
	output run_cmd_t      pop_data
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	run_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = cnt_q == FULL_CNT;
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from an empty queue");
	a_ptrs_match_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_q == rd_q)
		else $error("empty queue with unequal pointers");

endmodule
`default_nettype wire

>>> sv/rsd_back.sv
// Back end: applies run commands to the column and row counters and holds
// the result in an output register. Depends on rsd_pkg.
`default_nettype none
module rsd_back import rsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] frame_width,
	input  wire logic [7:0] frame_height,
	input  wire logic       cmd_avail,
	input  wire run_cmd_t   cmd,
	output logic            cmd_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output run_item_t       out_item
);

	logic [8:0] col_q, col_d, col_sum, row_inc;
	logic [7:0] row_q, row_d;
	logic       valid_q;
	run_item_t  item_q, item_d;

	assign cmd_pop   = cmd_avail && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_comb begin
		col_sum          = col_q + {2'b00, cmd.len};
		row_inc          = {1'b0, row_q} + 9'd1;
		item_d.pixel_value = cmd.value;
		item_d.run_length  = cmd.len;
		item_d.overrun     = col_sum > {1'b0, frame_width};
		item_d.row_end     = cmd.group_done && (col_sum >= {1'b0, frame_width});
		item_d.frame_end   = item_d.row_end && (row_inc >= {1'b0, frame_height});
		col_d = item_d.row_end ? '0 : col_sum;
		row_d = item_d.row_end ? (item_d.frame_end ? '0 : row_inc[7:0]) : row_q;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			item_q <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cmd_pop) begin
				valid_q <= 1'b1;
				col_q   <= col_d;
				row_q   <= row_d;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_row_end_clears_col: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && item_q.row_end |-> col_q == '0)
		else $error("column count not cleared at row end");
	a_frame_needs_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && item_q.frame_end |-> item_q.row_end && row_q == '0)
		else $error("frame end without row end or row reset");
	a_stall_holds_counters: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> $stable(col_q) && $stable(row_q))
		else $error("counters moved while result stalled");

endmodule
`default_nettype wire

>>> sv/rle_sprite_row_decoder.sv
// Sprite row RLE decoder top level: APB registers, front end, queue, back end.
// A run command is written into the queue, then registered in the back-end output register.
// Throughput: one code byte per cycle unless the queue is full (combinational decode).
// Reset (arst_n, asynchronous): control phase, counters zero, queue and output empty,
// frame_width and frame_height back to 64. Depends on rsd_pkg and rsd_stream_if.
`default_nettype none
module rle_sprite_row_decoder import rsd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	rsd_stream_if.sink              code,
	rsd_stream_if.source            run
);

	logic [7:0] width_q, height_q;
	logic       cfg_wr;
	logic       q_full, q_push, q_pop, q_avail;
	run_cmd_t   push_cmd, pop_cmd;
	run_item_t  out_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = {24'd0, width_q};
			REG_FRAME_HEIGHT: prdata = {24'd0, height_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RESET;
			height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FRAME_WIDTH) begin
				width_q <= pwdata[7:0];
			end else begin
				height_q <= pwdata[7:0];
			end
		end
	end

	rsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (code.valid),
		.in_ready  (code.ready),
		.code_byte (code.data.code_byte),
		.cmd_full  (q_full),
		.cmd_push  (q_push),
		.cmd       (push_cmd)
	);

	rsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.pop_data  (pop_cmd)
	);

	rsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (width_q),
		.frame_height (height_q),
		.cmd_avail    (q_avail),
		.cmd          (pop_cmd),
		.cmd_pop      (q_pop),
		.out_valid    (run.valid),
		.out_ready    (run.ready),
		.out_item     (out_item)
	);

	assign run.data = out_item;

endmodule
`default_nettype wire

>>> bench/tb_rle_sprite_row_decoder.sv
// Testbench for rle_sprite_row_decoder: drives code bytes, predicts pixel runs and checks them.
// It programs frame sizes over the register port and checks their read-back.
// Depends on rsd_pkg, rsd_stream_if and the decoder top level.
module tb_rle_sprite_row_decoder;
	import rsd_pkg::*;

	localparam int PHASES = 9;
	localparam int BYTES_PER_PHASE = 190;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rsd_stream_if #(.item_t(code_item_t)) code_if ();
	rsd_stream_if #(.item_t(run_item_t)) run_if ();

	rle_sprite_row_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.code(code_if),
		.run(run_if)
	);

	always #2 clk = ~clk;

	logic [7:0] code_bytes_q[$];
	run_item_t runs_expected[$];
	int mismatches = 0;
	int reg_errors = 0;
	int send_gap = 0;
	bit send_burst = 1'b0;
	int recv_gap = 0;
	bit recv_burst = 1'b0;

	// Decoder state as the block should hold it.
	logic [7:0] width_cfg = FRAME_WIDTH_RESET;
	logic [7:0] height_cfg = FRAME_HEIGHT_RESET;
	phase_t dec_phase = PHASE_CTRL;
	logic [5:0] pend_count = 6'd0;
	logic [8:0] col_count = 9'd0;
	logic [7:0] row_count = 8'd0;

	function automatic run_item_t account_run(input logic [7:0] value, input logic [6:0] len,
			input bit group_done);
		run_item_t r;
		col_count = col_count + 9'(len);
		r.pixel_value = value;
		r.run_length = len;
		r.row_end = 1'b0;
		r.frame_end = 1'b0;
		r.overrun = col_count > {1'b0, width_cfg};
		if (group_done && col_count >= {1'b0, width_cfg}) begin
			r.row_end = 1'b1;
			col_count = 9'd0;
			if ({1'b0, row_count} + 9'd1 >= {1'b0, height_cfg}) begin
				r.frame_end = 1'b1;
				row_count = 8'd0;
			end else begin
				row_count = row_count + 8'd1;
			end
		end
		return r;
	endfunction

	function automatic bit decode_code_byte(input logic [7:0] b, output run_item_t r);
		logic [5:0] n;
		r = '0;
		case (dec_phase)
			PHASE_REPEAT: begin
				n = pend_count;
				dec_phase = PHASE_CTRL;
				pend_count = 6'd0;
				if (n == 6'd0) return 1'b0;
				r = account_run(b, 7'(n), 1'b1);
				return 1'b1;
			end
			PHASE_LITERAL: begin
				pend_count = pend_count - 6'd1;
				if (pend_count == 6'd0) dec_phase = PHASE_CTRL;
				r = account_run(b, 7'd1, pend_count == 6'd0);
				return 1'b1;
			end
			default: begin
				dec_phase = PHASE_CTRL;
				if ((b & CTRL_TRANSPARENT_BIT) != 8'd0) begin
					if (b[6:0] == 7'd0) return 1'b0;
					r = account_run(TRANSPARENT_VALUE, b[6:0], 1'b1);
					return 1'b1;
				end
				if ((b & CTRL_REPEAT_BIT) != 8'd0) begin
					dec_phase = PHASE_REPEAT;
					pend_count = b[5:0];
				end else if (b[5:0] != 6'd0) begin
					dec_phase = PHASE_LITERAL;
					pend_count = b[5:0];
				end
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			code_if.valid <= 1'b0;
			send_gap <= 0;
		end else if (!code_if.valid || code_if.ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				code_if.valid <= 1'b0;
			end else if (code_bytes_q.size() != 0) begin
				code_if.data <= code_item_t'(code_bytes_q.pop_front());
				code_if.valid <= 1'b1;
				if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
				send_gap <= send_burst ? 0 : $urandom_range(0, 9);
			end else begin
				code_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			run_if.ready <= 1'b0;
			recv_gap <= 0;
		end else if (recv_gap != 0) begin
			recv_gap <= recv_gap - 1;
			run_if.ready <= (recv_gap == 1);
		end else if (run_if.valid && run_if.ready) begin
			if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
			if (!recv_burst && $urandom_range(0, 1) == 1) begin
				recv_gap <= $urandom_range(1, 9);
				run_if.ready <= 1'b0;
			end else begin
				run_if.ready <= 1'b1;
			end
		end else begin
			run_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : run_monitor
		run_item_t want;
		run_item_t got;
		run_item_t next_run;
		if (arst_n) begin
			if (run_if.valid && run_if.ready) begin
				got = run_if.data;
				if (runs_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected run transfer: value %0d len %0d row_end %0b frame_end %0b overrun %0b",
							got.pixel_value, got.run_length, got.row_end, got.frame_end,
							got.overrun);
				end else begin
					want = runs_expected.pop_front();
					if (got.pixel_value !== want.pixel_value || got.run_length !== want.run_length ||
							got.row_end !== want.row_end || got.frame_end !== want.frame_end ||
							got.overrun !== want.overrun) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Run mismatch: expected %0d/%0d/%0b/%0b/%0b, got %0d/%0d/%0b/%0b/%0b",
								want.pixel_value, want.run_length, want.row_end,
								want.frame_end, want.overrun, got.pixel_value,
								got.run_length, got.row_end, got.frame_end, got.overrun);
					end
				end
			end
			if (code_if.valid && code_if.ready) begin
				if (decode_code_byte(code_if.data.code_byte, next_run))
					runs_expected.push_back(next_run);
			end
		end
	end

	task automatic program_reg(input logic reg_idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({reg_idx, 2'b00});
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_FRAME_WIDTH) width_cfg = value;
		else height_cfg = value;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== 32'(value)) begin
			reg_errors++;
			$display("Register %0d read back %0h, expected %0h", reg_idx, prdata, value);
		end
	endtask

	task automatic wait_idle();
		while (code_bytes_q.size() != 0 || code_if.valid) @(negedge clk);
		while (runs_expected.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly well-formed groups sized to fill rows, with some oversize groups and noise.
	task automatic queue_rows(input int n_bytes);
		int sent;
		int pick;
		int room;
		int n;
		int col;
		sent = 0;
		col = 0;
		while (sent < n_bytes) begin
			room = int'(width_cfg) - col;
			if (room < 1) room = 1;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				code_bytes_q.push_back(8'($urandom));
				sent++;
			end else if (pick < 38) begin
				n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) :
					$urandom_range(1, room > 127 ? 127 : room);
				code_bytes_q.push_back(CTRL_TRANSPARENT_BIT | 8'(n));
				sent++;
				col += n;
			end else begin
				n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) :
					$urandom_range(1, room > 63 ? 63 : room);
				if (pick < 63) begin
					code_bytes_q.push_back(CTRL_REPEAT_BIT | 8'(n));
					code_bytes_q.push_back(8'($urandom));
					sent += 2;
				end else begin
					code_bytes_q.push_back(8'(n));
					repeat (n) code_bytes_q.push_back(8'($urandom));
					sent += n + 1;
				end
				col += n;
			end
			if (col >= int'(width_cfg)) col = 0;
		end
	endtask

	initial begin
		logic [7:0] widths[PHASES] = '{8'd64, 8'd1, 8'd255, 8'd7, 8'd0, 8'd2, 8'd255, 8'd13, 8'd64};
		logic [7:0] heights[PHASES] = '{8'd64, 8'd1, 8'd255, 8'd3, 8'd0, 8'd255, 8'd1, 8'd5, 8'd64};
		logic [7:0] opening[] = '{8'h80, 8'h00, 8'h40, 8'h12, 8'hFF, 8'h7F, 8'h00, 8'h02, 8'hFF,
			8'h00, 8'h41, 8'hAB, 8'h81, 8'hC5, 8'h43, 8'h55, 8'h01, 8'h7E, 8'h3F, 8'h01, 8'h80,
			8'hBF, 8'h01, 8'hC0};
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		code_if.valid = 1'b0;
		code_if.data = '0;
		run_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (opening[i]) code_bytes_q.push_back(opening[i]);
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_idle();
				program_reg(REG_FRAME_WIDTH, widths[p]);
				program_reg(REG_FRAME_HEIGHT, heights[p]);
			end
			queue_rows(BYTES_PER_PHASE);
		end
		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && reg_errors == 0 && runs_expected.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
